// File: sv/periodic_offset_coincidence_merge_macros.svh
// Assertion macros for the periodic offset coincidence merge block.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef PERIODIC_OFFSET_COINCIDENCE_MERGE_MACROS_SVH
`define PERIODIC_OFFSET_COINCIDENCE_MERGE_MACROS_SVH
`ifndef ASSERT_OFF
`define POCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define POCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define POCM_ASSERT_IMP(lbl, ante, cons, msg)
`define POCM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/pocm_pkg.sv
// Shared types and widths for the periodic offset coincidence merge block.
// No dependencies.
package pocm_pkg;

    localparam int TIME_BITS  = 20;
    localparam int HYPER_BITS = 48;
    localparam int A_BITS     = (HYPER_BITS > TIME_BITS) ? HYPER_BITS : TIME_BITS;
    localparam int P_BITS     = A_BITS + TIME_BITS;
    localparam int D_BITS     = (2 * TIME_BITS > HYPER_BITS) ? 2 * TIME_BITS : HYPER_BITS;
    localparam int S_BITS     = TIME_BITS + 2;
    localparam int DCNT_BITS  = $clog2(D_BITS + 1);
    localparam int MCNT_BITS  = $clog2(TIME_BITS + 1);

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [HYPER_BITS-1:0] t_hyper;
    typedef logic [A_BITS-1:0]     t_aw;
    typedef logic [P_BITS-1:0]     t_prod;
    typedef logic [D_BITS-1:0]     t_dw;
    typedef logic signed [S_BITS-1:0] t_sgn;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_SINGLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    typedef struct packed {
        logic  start_set;
        t_time msg_period;
        t_time msg_offset;
    } t_in_beat;

    typedef struct packed {
        t_hyper  coincide_instant;
        t_hyper  hyper_period;
        t_status merge_status;
    } t_out_beat;

    typedef struct packed {
        logic go;
        logic narrow;
    } t_div_req;

endpackage

// File: sv/pocm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pocm_pkg; a narrow request runs only TIME_BITS steps.
module pocm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pocm_pkg::t_div_req i_req,
    input  pocm_pkg::t_dw     i_dividend,
    input  pocm_pkg::t_dw     i_divisor,
    output logic              o_done,
    output pocm_pkg::t_dw     o_quot,
    output pocm_pkg::t_dw     o_rem
);

    logic                             r_busy;
    logic                             r_done;
    logic [pocm_pkg::DCNT_BITS-1:0]   r_cnt;
    pocm_pkg::t_dw                    r_rem;
    pocm_pkg::t_dw                    r_quo;
    pocm_pkg::t_dw                    r_dvs;
    logic [pocm_pkg::D_BITS:0]        rem_sh;
    logic [pocm_pkg::D_BITS:0]        trial;
    logic                             ge;

    assign rem_sh = {r_rem, r_quo[pocm_pkg::D_BITS-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};
    assign ge     = !trial[pocm_pkg::D_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                if (i_req.narrow) begin
                    r_quo <= i_dividend << (pocm_pkg::D_BITS - pocm_pkg::TIME_BITS);
                    r_cnt <= pocm_pkg::DCNT_BITS'(pocm_pkg::TIME_BITS);
                end else begin
                    r_quo <= i_dividend;
                    r_cnt <= pocm_pkg::DCNT_BITS'(pocm_pkg::D_BITS);
                end
            end else if (r_busy) begin
                r_rem <= ge ? trial[pocm_pkg::D_BITS-1:0] : rem_sh[pocm_pkg::D_BITS-1:0];
                r_quo <= {r_quo[pocm_pkg::D_BITS-2:0], ge};
                r_cnt <= r_cnt - pocm_pkg::DCNT_BITS'(1);
                if (r_cnt == pocm_pkg::DCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: sv/pocm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on pocm_pkg.
module pocm_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  pocm_pkg::t_aw   i_a,
    input  pocm_pkg::t_time i_b,
    output logic            o_done,
    output pocm_pkg::t_prod o_prod
);

    logic                            r_busy;
    logic                            r_done;
    logic [pocm_pkg::MCNT_BITS-1:0]  r_cnt;
    pocm_pkg::t_prod                 r_p;
    pocm_pkg::t_aw                   r_a;
    logic [pocm_pkg::A_BITS:0]       sum;

    assign sum = {1'b0, r_p[pocm_pkg::P_BITS-1:pocm_pkg::TIME_BITS]}
               + {1'b0, (r_p[0] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go && !r_busy) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_p    <= {{pocm_pkg::A_BITS{1'b0}}, i_b};
                r_cnt  <= pocm_pkg::MCNT_BITS'(pocm_pkg::TIME_BITS);
            end else if (r_busy) begin
                r_p   <= {sum, r_p[pocm_pkg::TIME_BITS-1:1]};
                r_cnt <= r_cnt - pocm_pkg::MCNT_BITS'(1);
                if (r_cnt == pocm_pkg::MCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// File: sv/periodic_offset_coincidence_merge.sv
// Top level of the periodic offset coincidence merge; uses pocm_pkg, pocm_div,
// pocm_mul and the assertion macros header.
//
// Each input beat carries one periodic message (period, offset, start flag). The
// block folds it into a running set: the hyperperiod (lcm of all periods) and the
// least instant at which every message of the set is released together. A start
// beat reloads the set (status single); a following beat merges (status found).
// If two offsets can never coincide, or the hyperperiod no longer fits in 48 bits,
// the status sticks at no-coincidence or overflow, instant and hyperperiod read
// zero, and the set is frozen until the next start beat. Zero periods count as 1.
// One beat is in work at a time. All division and multiplication runs through one
// bit-serial divider (narrow when the dividend fits the time field) and one
// bit-serial multiplier. The result sits in an output register, so the next beat
// is taken while it waits.
module periodic_offset_coincidence_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pocm_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pocm_pkg::t_out_beat o_out
);

`include "periodic_offset_coincidence_merge_macros.svh"

    localparam int TB = pocm_pkg::TIME_BITS;
    localparam int HB = pocm_pkg::HYPER_BITS;
    localparam int DB = pocm_pkg::D_BITS;
    localparam int SB = pocm_pkg::S_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_OFFMOD, S_GCD, S_CHKA, S_CHKB, S_Q1, S_M, S_OVCHK, S_A1M,
        S_DD, S_INVU, S_INVDIV, S_INVMUL, S_INVFIX, S_KMUL, S_KDIV, S_OMUL, S_OUT
    } t_state;

    t_state              r_state;
    logic                r_wait;     // unit op in flight
    logic                r_start;
    pocm_pkg::t_time     r_per;
    pocm_pkg::t_time     r_off;
    // merge state
    pocm_pkg::t_hyper    r_p1;
    pocm_pkg::t_hyper    r_a1;
    pocm_pkg::t_status   r_sticky;
    // scratch
    pocm_pkg::t_hyper    r_x;
    pocm_pkg::t_hyper    r_y;
    pocm_pkg::t_time     r_g;
    pocm_pkg::t_hyper    r_q1;
    pocm_pkg::t_time     r_m;
    pocm_pkg::t_time     r_dd;
    pocm_pkg::t_time     r_r0;
    pocm_pkg::t_time     r_r1;
    pocm_pkg::t_time     r_q;
    pocm_pkg::t_sgn      r_s0;
    pocm_pkg::t_sgn      r_s1;
    pocm_pkg::t_time     r_inv;
    pocm_pkg::t_dw       r_kp;
    pocm_pkg::t_hyper    r_lcm;
    // output register
    logic                r_out_valid;
    pocm_pkg::t_out_beat r_out;

    pocm_pkg::t_div_req  div_req;
    pocm_pkg::t_dw       div_a;
    pocm_pkg::t_dw       div_b;
    logic                div_done;
    pocm_pkg::t_dw       div_quot;
    pocm_pkg::t_dw       div_rem;
    logic                mul_go;
    pocm_pkg::t_aw       mul_a;
    pocm_pkg::t_time     mul_b;
    logic                mul_done;
    pocm_pkg::t_prod     mul_prod;

    logic                div_use;
    logic                mul_use;
    logic                in_acc;
    logic                out_load;
    pocm_pkg::t_time     in_per;
    pocm_pkg::t_time     rem_t;
    pocm_pkg::t_time     abs_s0;
    pocm_pkg::t_time     abs_s1;
    pocm_pkg::t_sgn      pm;
    logic [TB:0]         dsum;
    logic [TB:0]         dred;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign in_per   = (i_in.msg_period == '0) ? TB'(1) : i_in.msg_period;
    assign rem_t    = div_rem[TB-1:0];
    assign abs_s0   = r_s0[SB-1] ? TB'(-r_s0) : TB'(r_s0);
    assign abs_s1   = r_s1[SB-1] ? TB'(-r_s1) : TB'(r_s1);
    assign pm       = SB'(mul_prod);
    // (off + per - a1 mod per) mod per, value stays below twice per
    assign dsum     = {1'b0, r_off} + {1'b0, r_per} - {1'b0, rem_t};
    assign dred     = (dsum >= {1'b0, r_per}) ? dsum - {1'b0, r_per} : dsum;

    // operand select for the shared units
    always_comb begin
        div_use = 1'b0;
        mul_use = 1'b0;
        div_a   = '0;
        div_b   = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_OFFMOD: begin
                div_use = 1'b1; div_a = DB'(r_off); div_b = DB'(r_per);
            end
            S_GCD: begin
                div_use = (r_y != '0); div_a = DB'(r_x); div_b = DB'(r_y);
            end
            S_CHKA: begin
                div_use = 1'b1; div_a = DB'(r_a1); div_b = DB'(r_g);
            end
            S_CHKB: begin
                div_use = 1'b1; div_a = DB'(r_off); div_b = DB'(r_g);
            end
            S_Q1: begin
                div_use = 1'b1; div_a = DB'(r_p1); div_b = DB'(r_g);
            end
            S_M: begin
                div_use = 1'b1; div_a = DB'(r_per); div_b = DB'(r_g);
            end
            S_OVCHK: begin
                mul_use = 1'b1; mul_a = pocm_pkg::A_BITS'(r_q1); mul_b = r_per;
            end
            S_A1M: begin
                div_use = 1'b1; div_a = DB'(r_a1); div_b = DB'(r_per);
            end
            S_DD: begin
                div_use = 1'b1; div_a = DB'(r_dd); div_b = DB'(r_g);
            end
            S_INVU: begin
                div_use = 1'b1; div_a = DB'(r_q1); div_b = DB'(r_m);
            end
            S_INVDIV: begin
                div_use = (r_r1 != '0); div_a = DB'(r_r0); div_b = DB'(r_r1);
            end
            S_INVMUL: begin
                mul_use = 1'b1; mul_a = pocm_pkg::A_BITS'(r_q); mul_b = abs_s1;
            end
            S_INVFIX: begin
                div_use = 1'b1; div_a = DB'(abs_s0); div_b = DB'(r_m);
            end
            S_KMUL: begin
                mul_use = 1'b1; mul_a = pocm_pkg::A_BITS'(r_dd); mul_b = r_inv;
            end
            S_KDIV: begin
                div_use = 1'b1; div_a = r_kp; div_b = DB'(r_m);
            end
            S_OMUL: begin
                mul_use = 1'b1; mul_a = pocm_pkg::A_BITS'(r_p1); mul_b = r_inv;
            end
            default: begin
            end
        endcase
        div_req.go     = div_use && !r_wait;
        div_req.narrow = ((div_a >> TB) == '0);
        mul_go         = mul_use && !r_wait;
    end

    pocm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pocm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_p1        <= HB'(1);
            r_a1        <= '0;
            r_sticky    <= pocm_pkg::ST_FOUND;
            r_out_valid <= 1'b0;
        end else begin
            // a beat leaving while the next one loads keeps valid high
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (div_req.go || mul_go) begin
                r_wait <= 1'b1;
            end
            if (div_done || mul_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_start <= i_in.start_set;
                        r_per   <= in_per;
                        r_off   <= i_in.msg_offset;
                        r_state <= S_OFFMOD;
                    end
                end
                S_OFFMOD: begin
                    if (div_done) begin
                        r_off <= rem_t;
                        if (r_start) begin
                            if ((r_per >> HB) != '0) begin
                                r_sticky <= pocm_pkg::ST_OVER;
                                r_p1     <= HB'(1);
                                r_a1     <= '0;
                            end else begin
                                r_sticky <= pocm_pkg::ST_FOUND;
                                r_p1     <= HB'(r_per);
                                r_a1     <= HB'(rem_t);
                            end
                            r_state <= S_OUT;
                        end else if (r_sticky != pocm_pkg::ST_FOUND) begin
                            r_state <= S_OUT;
                        end else begin
                            r_x     <= r_p1;
                            r_y     <= HB'(r_per);
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (!r_wait && (r_y == '0)) begin
                        r_g     <= r_x[TB-1:0];
                        r_state <= S_CHKA;
                    end else if (div_done) begin
                        r_x <= r_y;
                        r_y <= HB'(div_rem);
                    end
                end
                S_CHKA: begin
                    if (div_done) begin
                        r_r0    <= rem_t;
                        r_state <= S_CHKB;
                    end
                end
                S_CHKB: begin
                    if (div_done) begin
                        if (rem_t != r_r0) begin
                            r_sticky <= pocm_pkg::ST_NONE;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_Q1;
                        end
                    end
                end
                S_Q1: begin
                    if (div_done) begin
                        r_q1    <= HB'(div_quot);
                        r_state <= S_M;
                    end
                end
                S_M: begin
                    if (div_done) begin
                        r_m     <= div_quot[TB-1:0];
                        r_state <= S_OVCHK;
                    end
                end
                S_OVCHK: begin
                    if (mul_done) begin
                        if ((mul_prod >> HB) != '0) begin
                            r_sticky <= pocm_pkg::ST_OVER;
                            r_state  <= S_OUT;
                        end else begin
                            r_lcm   <= HB'(mul_prod);
                            r_state <= S_A1M;
                        end
                    end
                end
                S_A1M: begin
                    if (div_done) begin
                        r_dd    <= dred[TB-1:0];
                        r_state <= S_DD;
                    end
                end
                S_DD: begin
                    if (div_done) begin
                        r_dd    <= div_quot[TB-1:0];
                        r_state <= S_INVU;
                    end
                end
                S_INVU: begin
                    if (div_done) begin
                        r_r0 <= r_m;
                        r_r1 <= rem_t;
                        r_s0 <= '0;
                        r_s1 <= SB'(1);
                        if (r_m == TB'(1)) begin
                            r_inv   <= '0;
                            r_state <= S_KMUL;
                        end else begin
                            r_state <= S_INVDIV;
                        end
                    end
                end
                S_INVDIV: begin
                    if (!r_wait && (r_r1 == '0)) begin
                        r_state <= S_INVFIX;
                    end else if (div_done) begin
                        r_q     <= div_quot[TB-1:0];
                        r_r0    <= r_r1;
                        r_r1    <= rem_t;
                        r_state <= S_INVMUL;
                    end
                end
                S_INVMUL: begin
                    if (mul_done) begin
                        r_s0    <= r_s1;
                        r_s1    <= r_s1[SB-1] ? r_s0 + pm : r_s0 - pm;
                        r_state <= S_INVDIV;
                    end
                end
                S_INVFIX: begin
                    if (div_done) begin
                        r_inv   <= r_s0[SB-1] ? r_m - rem_t : rem_t;
                        r_state <= S_KMUL;
                    end
                end
                S_KMUL: begin
                    if (mul_done) begin
                        r_kp    <= DB'(mul_prod);
                        r_state <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    if (div_done) begin
                        r_inv   <= rem_t;
                        r_state <= S_OMUL;
                    end
                end
                S_OMUL: begin
                    if (mul_done) begin
                        r_a1    <= r_a1 + HB'(mul_prod);
                        r_p1    <= r_lcm;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        if (r_sticky != pocm_pkg::ST_FOUND) begin
                            r_out.coincide_instant <= '0;
                            r_out.hyper_period     <= '0;
                            r_out.merge_status     <= r_sticky;
                        end else begin
                            r_out.coincide_instant <= r_a1;
                            r_out.hyper_period     <= r_p1;
                            r_out.merge_status     <= r_start ? pocm_pkg::ST_SINGLE
                                                              : pocm_pkg::ST_FOUND;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `POCM_ASSERT_IMP(a_sticky_zero, o_out_valid && (o_out.merge_status == pocm_pkg::ST_NONE || o_out.merge_status == pocm_pkg::ST_OVER), o_out.coincide_instant == '0 && o_out.hyper_period == '0, "sticky result carries nonzero fields")
    `POCM_ASSERT_IMP(a_hyper_nz, o_out_valid && (o_out.merge_status == pocm_pkg::ST_FOUND || o_out.merge_status == pocm_pkg::ST_SINGLE), o_out.hyper_period != '0, "valid result with zero hyperperiod")
    `POCM_ASSERT_IMP(a_done_waited, div_done || mul_done, r_wait, "unit finished with no op in flight")
    `POCM_ASSERT_NXT(a_accept_busy, in_acc, o_in_stall, "block not busy after accepting a beat")

endmodule
